FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file blt_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");
`endif

FILE: rtl/core/blt_pkg.sv
// Package for the bounded logit transform: types, constants and stage records.
// No dependencies.
`default_nettype none
package blt_pkg;
    localparam int FRAC_BITS = 16;
    localparam int NSQ = 32;                      // fraction bits of log2
    localparam int LAT = NSQ + 6;                 // pipeline depth of the back part
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NUDGE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [0:0] REG_EDGE_NUDGE = 1'b0;

    // classified item handed from front to back
    typedef struct packed {
        logic        ok;
        logic [1:0]  status;
        logic [32:0] num;     // x-a, positive when ok
        logic [32:0] den;     // b-x, positive when ok
    } t_item;

    // one log2 lane in flight
    typedef struct packed {
        logic [5:0]  e;
        logic [32:0] m;
        logic [31:0] frac;
    } t_lg;
endpackage
`default_nettype wire

FILE: rtl/core/blt_front.sv
// Front part: classify an item against its bounds and apply the edge nudge.
// Depends on blt_pkg.
`default_nettype none
module blt_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire signed [31:0]     i_x,
    input  wire signed [31:0]     i_a,
    input  wire signed [31:0]     i_b,
    input  wire [15:0]            i_nudge,
    output logic                  o_vld,
    output blt_pkg::t_item        o_item
);
    logic signed [33:0] xn;
    logic signed [33:0] n, d;
    blt_pkg::t_item n_item;
    blt_pkg::t_item r_item;
    logic r_vld;

    always_comb begin
        n_item = '0;
        n_item.status = blt_pkg::ST_INVALID;
        xn = {{2{i_x[31]}}, i_x};
        n = '0;
        d = '0;
        if (!(i_a >= i_b || i_x < i_a || i_x > i_b)) begin
            n_item.status = blt_pkg::ST_OK;
            if (i_x == i_a) begin
                xn = xn + $signed({18'd0, i_nudge});
                n_item.status = blt_pkg::ST_NUDGE;
            end else if (i_x == i_b) begin
                xn = xn - $signed({18'd0, i_nudge});
                n_item.status = blt_pkg::ST_NUDGE;
            end
            n = xn - {{2{i_a[31]}}, i_a};
            d = {{2{i_b[31]}}, i_b} - xn;
            if (n <= 0 || d <= 0) begin
                n_item.status = blt_pkg::ST_INVALID;
            end else begin
                n_item.ok = 1'b1;
                n_item.num = n[32:0];
                n_item.den = d[32:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_start;
        end
        r_item <= n_item;
    end

    assign o_vld = r_vld;
    assign o_item = r_item;
endmodule
`default_nettype wire

FILE: rtl/core/blt_queue.sv
// Short two-entry queue between front and back parts.
// Depends on blt_pkg.
`default_nettype none
module blt_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  blt_pkg::t_item        i_item,
    output logic                  o_vld,
    output blt_pkg::t_item        o_item
);
    // back part never stalls, so pop whenever an entry is there
    blt_pkg::t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (r_cnt != 2'd0) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, r_cnt != 2'd0};
        end
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_vld = (r_cnt != 2'd0);
    assign o_item = r_mem[r_rp];
endmodule
`default_nettype wire

FILE: rtl/core/blt_back.sv
// Back part: pipelined log2 of both terms, difference, scale by ln 2, round, saturate.
// Depends on blt_pkg.
`default_nettype none
module blt_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_vld,
    input  blt_pkg::t_item        i_item,
    output logic                  o_vld,
    output logic signed [31:0]    o_logit,
    output logic [1:0]            o_status
);
    localparam int N = blt_pkg::NSQ;

    function automatic blt_pkg::t_lg norm(input logic [32:0] v);
        blt_pkg::t_lg r;
        logic [5:0] e;
        e = '0;
        for (int i = 0; i < 33; i++) if (v[i]) e = 6'(i);
        r.e = e;
        r.frac = '0;
        if (e <= 6'd31) r.m = 33'(v << (6'd31 - e));
        else r.m = 33'(v >> (e - 6'd31));
        return r;
    endfunction

    function automatic blt_pkg::t_lg sqstep(input blt_pkg::t_lg s);
        blt_pkg::t_lg r;
        logic [63:0] p;
        p = 64'(s.m[31:0]) * 64'(s.m[31:0]);
        r = s;
        if (p[63]) begin
            r.m = {1'b0, p[63:32]};
            r.frac = {s.frac[30:0], 1'b1};
        end else begin
            r.m = {1'b0, p[62:31]};
            r.frac = {s.frac[30:0], 1'b0};
        end
        return r;
    endfunction

    logic            r_v   [blt_pkg::LAT];
    logic [2:0]      r_st  [blt_pkg::LAT];  // {ok, status}
    blt_pkg::t_lg    r_ln  [N+1];
    blt_pkg::t_lg    r_ld  [N+1];
    logic signed [38:0] r_l;
    logic [37:0]     r_mag;
    logic [63:0]     r_p0, r_p1;
    logic signed [31:0] r_res;
    logic            r_neg [3];
    logic [32:0]     r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < blt_pkg::LAT; i++) r_v[i] <= 1'b0;
        end else begin
            r_v[0] <= i_vld;
            for (int i = 1; i < blt_pkg::LAT; i++) r_v[i] <= r_v[i-1];
        end
        r_st[0] <= {i_item.ok, i_item.status};
        for (int i = 1; i < blt_pkg::LAT; i++) r_st[i] <= r_st[i-1];
        r_ln[0] <= norm(i_item.ok ? i_item.num : 33'd1);
        r_ld[0] <= norm(i_item.ok ? i_item.den : 33'd1);
        for (int i = 1; i <= N; i++) begin
            r_ln[i] <= sqstep(r_ln[i-1]);
            r_ld[i] <= sqstep(r_ld[i-1]);
        end
        // stage N+1: difference of the Q.32 logs
        r_l <= $signed({1'b0, r_ln[N].e, r_ln[N].frac})
             - $signed({1'b0, r_ld[N].e, r_ld[N].frac});
        // stage N+2: magnitude; the two ln2 products follow in stage N+3
        r_neg[0] <= r_l[38];
        r_mag <= 38'(r_l[38] ? -r_l : r_l);
        r_neg[1] <= r_neg[0];
        r_p0 <= 64'(r_mag[37:32]) * 64'(blt_pkg::LN2_Q32);
        r_p1 <= 64'(r_mag[31:0]) * 64'(blt_pkg::LN2_Q32);
        r_neg[2] <= r_neg[1];
        r_r <= 33'((r_p0 + 64'(r_p1[63:32]) + (64'd1 << (31 - blt_pkg::FRAC_BITS)))
               >> (32 - blt_pkg::FRAC_BITS));
        if (r_neg[2]) r_res <= (r_r >= 33'h80000000) ? 32'sh80000000 : -$signed(r_r[31:0]);
        else r_res <= (r_r > 33'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(r_r[31:0]);
    end

    assign o_vld = r_v[blt_pkg::LAT-1];
    assign o_logit = r_st[blt_pkg::LAT-1][2] ? r_res : 32'sd0;
    assign o_status = r_st[blt_pkg::LAT-1][1:0];
endmodule
`default_nettype wire

FILE: rtl/core/bounded_logit_transform.sv
// Top level of the bounded logit transform: front, queue, back and APB register.
// Depends on blt_pkg, blt_front, blt_queue, blt_back.
//
// Takes one request per cycle (busy is always low) and returns
// logit_out = ln((x-a)/(b-x)) in Q16.16 with a status, one strobe per request,
// in order. After acceptance a request passes the front register (bound checks
// and edge nudge), the queue register, a normalize stage, 32 squaring stages of
// the log2 mantissa, then subtract, magnitude, ln 2 scale, round and saturate
// stages. The receiver cannot stall; o_valid is a one-cycle strobe. edge_nudge
// sits at APB address 0 (reset 1).
`default_nettype none
module bounded_logit_transform (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire signed [31:0] i_value_in,
    input  wire signed [31:0] i_lower_bound,
    input  wire signed [31:0] i_upper_bound,
    output logic              o_valid,
    output logic signed [31:0] o_logit_out,
    output logic [1:0]        o_status,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [0:0]         paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [15:0] r_nudge;
    logic f_vld, q_vld;
    blt_pkg::t_item f_item, q_item;

    // hold the nudge register; ignore unmapped addresses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nudge <= 16'd1;
        end else if (psel && penable && pwrite && paddr == blt_pkg::REG_EDGE_NUDGE) begin
            r_nudge <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == blt_pkg::REG_EDGE_NUDGE) ? {16'd0, r_nudge} : 32'd0;
    assign busy = 1'b0;

    blt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_x(i_value_in), .i_a(i_lower_bound), .i_b(i_upper_bound),
        .i_nudge(r_nudge), .o_vld(f_vld), .o_item(f_item)
    );

    blt_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_vld), .i_item(f_item),
        .o_vld(q_vld), .o_item(q_item)
    );

    blt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(q_vld), .i_item(q_item),
        .o_vld(o_valid), .o_logit(o_logit_out), .o_status(o_status)
    );
endmodule
`default_nettype wire

FILE: rtl/core/blt_checker.sv
// Port-level checker for bounded_logit_transform, bound to the top level.
// Depends on assert_macros.svh and blt_pkg.
`include "assert_macros.svh"
`default_nettype none
module blt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        busy,
    input wire        o_valid,
    input wire [31:0] o_logit_out,
    input wire [1:0]  o_status,
    input wire        pready
);
    `CHK_IMPL(a_status_range, i_clk, i_rst_n, o_valid, o_status != 2'd3)
    `CHK_IMPL(a_invalid_zero, i_clk, i_rst_n, o_valid && o_status == blt_pkg::ST_INVALID, o_logit_out == 32'd0)
    `CHK_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `CHK_NEXT(a_ready, i_clk, i_rst_n, 1'b1, pready)
endmodule
bind bounded_logit_transform blt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy), .o_valid(o_valid),
    .o_logit_out(o_logit_out), .o_status(o_status), .pready(pready)
);
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for bounded_logit_transform: command-style requests,
// APB writes of edge_nudge, and a scoreboard that predicts ln((x-a)/(b-x)) in Q16.16.
// Depends on blt_pkg and the bounded_logit_transform RTL.
`default_nettype none

// Predicts each result from an accepted request and checks the strobed results in order.
class logit_scoreboard;
    logic [15:0]  nudge_lsbs;
    logic [31:0]  exp_logit_q[$];
    logic [1:0]   exp_status_q[$];
    int           mismatches;
    int           results_seen;
    int           nudged_seen;
    int           invalid_seen;

    function new();
        nudge_lsbs = 16'd1;
        mismatches = 0;
        results_seen = 0;
        nudged_seen = 0;
        invalid_seen = 0;
    endfunction

    // log2 of a positive integer, integer part above bit 32, 32 fraction bits
    function logic [63:0] log2_fixed(logic [63:0] v);
        int          e;
        logic [63:0] m;
        logic [31:0] frac;
        e = 0;
        frac = 0;
        while (e < 63 && (v >> (e + 1)) != 0)
            e++;
        if (e <= 31)
            m = v << (31 - e);
        else
            m = v >> (e - 31);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {e[31:0], frac};
    endfunction

    // Note an accepted request and queue the result it must produce.
    function void note_request(logic signed [31:0] xv, logic signed [31:0] av,
                               logic signed [31:0] bv);
        longint      x;
        longint      a;
        longint      b;
        longint      lg;
        longint      res;
        logic [63:0] mag;
        logic [63:0] t;
        logic [63:0] r;
        logic [1:0]  st;
        x = xv;
        a = av;
        b = bv;
        st = blt_pkg::ST_OK;
        if (a >= b || x < a || x > b) begin
            exp_logit_q.push_back(32'd0);
            exp_status_q.push_back(blt_pkg::ST_INVALID);
            return;
        end
        if (x == a) begin
            x = x + nudge_lsbs;
            st = blt_pkg::ST_NUDGE;
        end else if (x == b) begin
            x = x - nudge_lsbs;
            st = blt_pkg::ST_NUDGE;
        end
        if (x - a <= 0 || b - x <= 0) begin
            exp_logit_q.push_back(32'd0);
            exp_status_q.push_back(blt_pkg::ST_INVALID);
            return;
        end
        lg = longint'(log2_fixed(x - a)) - longint'(log2_fixed(b - x));
        mag = (lg < 0) ? -lg : lg;
        t = (mag >> 32) * blt_pkg::LN2_Q32
            + (((mag & 64'hFFFF_FFFF) * blt_pkg::LN2_Q32) >> 32);
        r = (t + (64'd1 << (31 - blt_pkg::FRAC_BITS))) >> (32 - blt_pkg::FRAC_BITS);
        if (r > 64'h8000_0000)
            r = 64'h8000_0000;
        if (lg < 0) begin
            res = -longint'(r);
        end else begin
            if (r > 64'h7FFF_FFFF)
                r = 64'h7FFF_FFFF;
            res = r;
        end
        exp_logit_q.push_back(res[31:0]);
        exp_status_q.push_back(st);
    endfunction

    // Compare one strobed result against the oldest expectation.
    function void check_result(logic [31:0] logit, logic [1:0] status);
        logic [31:0] el;
        logic [1:0]  es;
        results_seen++;
        if (exp_logit_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: logit_out=%h status=%0d", logit, status);
            return;
        end
        el = exp_logit_q.pop_front();
        es = exp_status_q.pop_front();
        if (es == blt_pkg::ST_NUDGE)
            nudged_seen++;
        if (es == blt_pkg::ST_INVALID)
            invalid_seen++;
        if (el !== logit || es !== status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: logit_out exp %h got %h, status exp %0d got %0d",
                         el, logit, es, status);
        end
    endfunction

    function int pending();
        return exp_logit_q.size();
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = blt_pkg::LAT + 10;   // covers the front, queue and back pipeline
    localparam int RAND_PER_PHASE = 320;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_value_in;
    logic signed [31:0] i_lower_bound;
    logic signed [31:0] i_upper_bound;
    logic               o_valid;
    logic signed [31:0] o_logit_out;
    logic [1:0]         o_status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [0:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    logit_scoreboard sb;
    int              requests_sent;

    bounded_logit_transform u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value_in    (i_value_in),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .o_valid       (o_valid),
        .o_logit_out   (o_logit_out),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Results cannot be held off: check every strobe at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_logit_out, o_status);
    end

    // Drive one request: hold start low for a random gap, then keep it high
    // until the block takes it. start stays high into the next request.
    task automatic send_request(logic [31:0] x, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_value_in <= x;
        i_lower_bound <= a;
        i_upper_bound <= b;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        sb.note_request(x, a, b);
        requests_sent++;
    endtask

    // Drop start, wait for every expected result, then let the pipe settle.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic apb_write(logic [0:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready)
                break;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.nudge_lsbs = data[15:0];
        @(posedge i_clk);
    endtask

    // Mostly well-formed requests: a < b with x inside or on a bound;
    // the rest is full-range noise.
    task automatic random_request();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] x;
        longint      span;
        int          kind;
        kind = $urandom_range(0, 9);
        a = $urandom;
        b = $urandom;
        if (kind <= 6) begin
            // narrow intervals often, so nudges can fall out of range
            if ($urandom_range(0, 3) == 0)
                b = a + $urandom_range(1, 70000);
            if ($signed(a) > $signed(b)) begin
                x = a;
                a = b;
                b = x;
            end
            if (a == b)
                b = a + 1;
            if ($signed(b) < $signed(a)) begin
                a = 32'h8000_0000;
                b = 32'h7FFF_FFFF;
            end
            span = longint'($signed(b)) - longint'($signed(a));
            case ($urandom_range(0, 5))
                0: x = a;
                1: x = b;
                default: x = a + 32'((longint'({$urandom, $urandom})
                                      & 64'h7FFF_FFFF_FFFF_FFFF) % (span + 1));
            endcase
        end else begin
            x = $urandom;
        end
        send_request(x, a, b);
    endtask

    initial begin
        logic [31:0] nudge_settings [4];
        sb = new();
        requests_sent = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_value_in = '0;
        i_lower_bound = '0;
        i_upper_bound = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset nudge of one LSB.
        send_request(32'h0000_8000, 32'h0000_0000, 32'h0001_0000); // unit support, midpoint
        send_request(32'h0000_0001, 32'h0000_0000, 32'h0001_0000); // near lower bound
        send_request(32'h0000_0000, 32'h0000_0000, 32'h0001_0000); // on lower bound
        send_request(32'h0001_0000, 32'h0000_0000, 32'h0001_0000); // on upper bound
        send_request(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF); // extreme span, low edge
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF); // extreme span, high edge
        send_request(32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF); // largest negative logit
        send_request(32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF); // largest positive logit
        send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000); // empty interval a == b
        send_request(32'h0000_0005, 32'h0000_0010, 32'h0000_0001); // a > b
        send_request(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000); // x below a
        send_request(32'h0001_0001, 32'h0000_0000, 32'h0001_0000); // x above b
        send_request(32'h0000_0010, 32'h0000_0010, 32'h0000_0011); // nudge lands on b
        send_request(32'h0000_0011, 32'h0000_0010, 32'h0000_0012); // one LSB either side
        send_request(32'hFFFF_0000, 32'hFFFE_0000, 32'h0000_0000); // negative bounds
        send_request(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001); // straddles zero

        // Random phases over several nudge settings, extremes included.
        nudge_settings[0] = 32'd1;
        nudge_settings[1] = 32'd65535;
        nudge_settings[2] = $urandom_range(2, 65534);
        nudge_settings[3] = 32'd1;
        for (int p = 0; p < 4; p++) begin
            drain();
            apb_write(blt_pkg::REG_EDGE_NUDGE, nudge_settings[p]);
            if (p == 1) begin
                // wide nudge at bounds of a narrow interval
                send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF);
                send_request(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
                send_request(32'h0002_0000, 32'h0000_0000, 32'h0002_0000);
            end
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                random_request();
                // stretches with no gaps come from the 1-in-4 zero draw and a zero gap draw;
                // once mid-phase, hold off until the pipe is empty
                if (k == RAND_PER_PHASE / 2) begin
                    start <= 1'b0;
                    while (sb.pending() != 0)
                        @(posedge i_clk);
                end
            end
        end
        drain();

        $display("covered %0d requests over 4 nudge settings: %0d nudged, %0d invalid",
                 requests_sent, sb.nudged_seen, sb.invalid_seen);
        $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
